@@ rtl/assert_macros.svh @@
// assertion macros used by the decompressor core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define CHK_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lzsd_pkg.sv @@
// types and constants of the lzss stream decompressor
package lzsd_pkg;

  localparam int HDR_BYTES   = 8;
  localparam int MIN_MATCH   = 2;
  localparam int MAX_RESULTS = 17;
  localparam int CNT_W       = 5;   // holds MAX_RESULTS
  localparam int LEN_W       = 9;   // match length plus MIN_MATCH, widest length field

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_FLAG,
    PH_ITEM,
    PH_WORD_HIGH,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT,
    ST_COPY
  } eng_state_t;

endpackage

@@ rtl/lzsd_ram.sv @@
// generic single-write, single-read ram with registered read data
module lzsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/lzss_stream_decompressor_core.sv @@
// lzss stream decompressor: header and flag parser, window copy engine
//
// input channel (in_valid/in_ready): one compressed byte per transfer, with
// start_of_stream high on the first of the eight header bytes. the header
// holds the compressed size (ignored) and the original size, little endian.
// output channel (out_valid/out_ready): one decompressed byte per transfer,
// last_of_run high on the final byte caused by an input byte, end_of_data
// high on the byte that completes the original size.
// flow: header and flag bytes and the low byte of a match word only update
// the parser; a literal or the high byte of a match word starts the engine,
// a match copying up to 17 bytes, paced by the single read port of the
// history window ram (one read issued per cycle unless the output stalls,
// registered read data).
// in_ready is high only while the copy engine is idle; a finished byte
// waiting in the output register does not hold off the next input byte.
// when the receiver stalls, the engine stops issuing reads and holds the
// pending ram byte until the output register frees up.
// reset: synchronous, clears parser and engine; the window reads as zero
// until written, tracked by the write pointer and a wrap flag, so no
// clearing pass is needed and input is taken from the first cycle.
`include "assert_macros.svh"

module lzss_stream_decompressor_core
  import lzsd_pkg::*;
#(
  parameter int OFFSET_BITS = 12
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       start_of_stream,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       end_of_data
);

  localparam int LEN_BITS = 16 - OFFSET_BITS;
  localparam int WIN_SIZE = 1 << OFFSET_BITS;

  // parser state
  phase_t      phase;
  logic [2:0]  header_index;
  logic [7:0]  flag_bits;
  logic [3:0]  flags_left;
  logic [7:0]  word_low_byte;
  logic [31:0] bytes_remaining;

  // window bookkeeping
  logic [OFFSET_BITS-1:0] wpos;
  logic                   wrapped;

  // copy engine
  eng_state_t             state, state_next;
  logic [7:0]             lit_byte;
  logic                   lit_eod;
  logic [CNT_W-1:0]       copy_left;
  logic [OFFSET_BITS-1:0] src;
  logic                   cp_hit;
  logic                   p_valid;
  logic                   p_last;
  logic                   p_fwd;
  logic                   p_zero;
  logic [7:0]             p_fwd_data;
  logic [7:0]             ram_rdata;
  logic [7:0]             p_byte;

  // parser next values
  phase_t      ph_c, phase_next;
  logic [2:0]  hidx_c, header_index_next;
  logic [7:0]  fb_c, flag_bits_next;
  logic [3:0]  fl_c, flags_left_next;
  logic [7:0]  wl_c, word_low_byte_next;
  logic [31:0] rem_c, bytes_remaining_next;
  logic        go_lit, go_copy, new_lit_eod, new_hit;
  logic [CNT_W-1:0]       new_cnt;
  logic [OFFSET_BITS-1:0] new_src;

  // match word fields
  logic [15:0]            word;
  logic [OFFSET_BITS-1:0] match_dist;
  logic [LEN_W-1:0]       len_full, len_cap;

  // handshake and datapath control
  logic accept, can_load, lit_done, p_done, issue, load;
  logic wr_en;
  logic [7:0] wr_data;
  logic [7:0] ld_byte;
  logic ld_last, ld_eod;

  assign accept   = in_valid && in_ready;
  assign can_load = !out_valid || out_ready;

  assign word       = {in_byte, wl_c};
  assign match_dist = word[15 -: OFFSET_BITS];
  assign len_full   = LEN_W'(word[LEN_BITS-1:0]) + LEN_W'(MIN_MATCH);
  assign len_cap    = (len_full > LEN_W'(MAX_RESULTS)) ? LEN_W'(MAX_RESULTS) : len_full;

  // parser: start_of_stream restarts before the byte is interpreted
  always_comb begin
    ph_c   = start_of_stream ? PH_HEADER : phase;
    hidx_c = start_of_stream ? 3'd0 : header_index;
    fb_c   = start_of_stream ? 8'd0 : flag_bits;
    fl_c   = start_of_stream ? 4'd0 : flags_left;
    wl_c   = start_of_stream ? 8'd0 : word_low_byte;
    rem_c  = start_of_stream ? 32'd0 : bytes_remaining;

    phase_next           = ph_c;
    header_index_next    = hidx_c;
    flag_bits_next       = fb_c;
    flags_left_next      = fl_c;
    word_low_byte_next   = wl_c;
    bytes_remaining_next = rem_c;
    go_lit      = 1'b0;
    go_copy     = 1'b0;
    new_lit_eod = 1'b0;
    new_hit     = 1'b0;
    new_cnt     = '0;
    new_src     = wpos - match_dist;

    unique case (ph_c)
      PH_HEADER: begin
        if (hidx_c[2]) begin
          case (hidx_c[1:0])
            2'd0:    bytes_remaining_next = rem_c | {24'd0, in_byte};
            2'd1:    bytes_remaining_next = rem_c | {16'd0, in_byte, 8'd0};
            2'd2:    bytes_remaining_next = rem_c | {8'd0, in_byte, 16'd0};
            default: bytes_remaining_next = rem_c | {in_byte, 24'd0};
          endcase
        end
        if (hidx_c == 3'(HDR_BYTES - 1)) begin
          header_index_next = 3'd0;
          phase_next = (bytes_remaining_next == 32'd0) ? PH_DONE : PH_FLAG;
        end else begin
          header_index_next = hidx_c + 3'd1;
        end
      end
      PH_FLAG: begin
        flag_bits_next  = in_byte;
        flags_left_next = 4'd8;
        phase_next      = PH_ITEM;
      end
      PH_ITEM: begin
        if (fb_c[0]) begin
          go_lit               = 1'b1;
          bytes_remaining_next = rem_c - 32'd1;
          new_lit_eod          = (bytes_remaining_next == 32'd0);
          flag_bits_next       = fb_c >> 1;
          flags_left_next      = fl_c - 4'd1;
          if (bytes_remaining_next == 32'd0) begin
            phase_next = PH_DONE;
          end else if (flags_left_next == 4'd0) begin
            phase_next = PH_FLAG;
          end else begin
            phase_next = PH_ITEM;
          end
        end else begin
          word_low_byte_next = in_byte;
          phase_next         = PH_WORD_HIGH;
        end
      end
      PH_WORD_HIGH: begin
        // copy is clipped at the original size and at MAX_RESULTS
        go_copy = 1'b1;
        new_hit = (rem_c <= 32'(len_cap));
        new_cnt = new_hit ? rem_c[CNT_W-1:0] : len_cap[CNT_W-1:0];
        bytes_remaining_next = rem_c - 32'(new_cnt);
        flag_bits_next       = fb_c >> 1;
        flags_left_next      = fl_c - 4'd1;
        if (bytes_remaining_next == 32'd0) begin
          phase_next = PH_DONE;
        end else if (flags_left_next == 4'd0) begin
          phase_next = PH_FLAG;
        end else begin
          phase_next = PH_ITEM;
        end
      end
      default: phase_next = PH_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_index    <= 3'd0;
      flag_bits       <= 8'd0;
      flags_left      <= 4'd0;
      word_low_byte   <= 8'd0;
      bytes_remaining <= 32'd0;
    end else if (accept) begin
      phase           <= phase_next;
      header_index    <= header_index_next;
      flag_bits       <= flag_bits_next;
      flags_left      <= flags_left_next;
      word_low_byte   <= word_low_byte_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  // engine next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && go_lit) begin
          state_next = ST_LIT;
        end else if (accept && go_copy) begin
          state_next = ST_COPY;
        end
      end
      ST_LIT: begin
        if (can_load) begin
          state_next = ST_IDLE;
        end
      end
      ST_COPY: begin
        if (copy_left == '0 && p_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // engine outputs
  always_comb begin
    in_ready = 1'b0;
    lit_done = 1'b0;
    p_done   = 1'b0;
    issue    = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_LIT:  lit_done = can_load;
      ST_COPY: begin
        p_done = p_valid && can_load;
        issue  = (copy_left != '0) && (!p_valid || p_done);
      end
      default: in_ready = 1'b0;
    endcase
  end

  // pending byte: forwarded write, never-written entry, or ram data
  assign p_byte = p_fwd ? p_fwd_data : (p_zero ? 8'd0 : ram_rdata);

  assign load    = lit_done || p_done;
  assign wr_en   = load;
  assign ld_byte = lit_done ? lit_byte : p_byte;
  assign ld_last = lit_done ? 1'b1 : p_last;
  assign ld_eod  = lit_done ? lit_eod : (p_last && cp_hit);
  assign wr_data = ld_byte;

  lzsd_ram #(
    .WIDTH (8),
    .DEPTH (WIN_SIZE)
  ) u_window (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wpos),
    .wdata (wr_data),
    .re    (issue),
    .raddr (src),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      copy_left <= '0;
      p_valid   <= 1'b0;
      wpos      <= '0;
      wrapped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && go_copy) begin
        copy_left <= new_cnt;
      end else if (issue) begin
        copy_left <= copy_left - CNT_W'(1);
      end
      if (issue) begin
        p_valid <= 1'b1;
      end else if (p_done) begin
        p_valid <= 1'b0;
      end
      if (wr_en) begin
        wpos <= wpos + OFFSET_BITS'(1);
        if (wpos == '1) begin
          wrapped <= 1'b1;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      lit_byte <= in_byte;
      lit_eod  <= new_lit_eod;
      cp_hit   <= new_hit;
    end
    if (accept && go_copy) begin
      src <= new_src;
    end else if (issue) begin
      src <= src + OFFSET_BITS'(1);
    end
    if (issue) begin
      p_last     <= (copy_left == CNT_W'(1));
      // same-cycle write to the read entry: the ram returns stale data
      p_fwd      <= wr_en && (wpos == src);
      p_fwd_data <= wr_data;
      p_zero     <= !(wrapped || (src < wpos));
    end
    if (load) begin
      out_byte    <= ld_byte;
      last_of_run <= ld_last;
      end_of_data <= ld_eod;
    end
  end

  `CHK_ALWAYS(a_idle_empty, clk, rst, !(in_ready && (p_valid || copy_left != '0)), "input taken while copy busy")
  `CHK_NEXT(a_load_shows, clk, rst, load, out_valid, "loaded byte not presented")
  `CHK_NEXT(a_wpos_step, clk, rst, wr_en, wpos == $past(wpos) + OFFSET_BITS'(1), "write pointer skipped")
  `CHK_NEXT(a_last_ends, clk, rst, p_done && p_last, state == ST_IDLE, "copy outlived its last byte")

endmodule

@@ tb/sv/lzsd_tb_pkg.sv @@
// scoreboard class for the lzss stream decompressor testbench
package lzsd_tb_pkg;
  import lzsd_pkg::*;

  localparam int WIN_BITS    = 12;
  localparam int LEN_BITS    = 16 - WIN_BITS;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eod;
  } plain_beat_t;

  class decomp_scoreboard;
    phase_t              phase;
    logic [2:0]          hdr_idx;
    logic [7:0]          flag_byte;
    logic [3:0]          flags_left;
    logic [7:0]          word_lo;
    logic [31:0]         remaining;
    logic [7:0]          window [1 << WIN_BITS];
    logic [WIN_BITS-1:0] wr_pos;
    plain_beat_t         pending_bytes [$];
    int                  errors;
    int                  seen;

    function new();
      phase      = PH_HEADER;
      hdr_idx    = '0;
      flag_byte  = '0;
      flags_left = '0;
      word_lo    = '0;
      remaining  = '0;
      wr_pos     = '0;
      errors     = 0;
      seen       = 0;
      foreach (window[i]) window[i] = '0;
    endfunction

    function void emit(logic [7:0] b);
      window[wr_pos] = b;
      wr_pos++;
      remaining--;
      pending_bytes.push_back('{data: b, last: 1'b0, eod: (remaining == 0)});
    endfunction

    function void next_flag();
      flag_byte = flag_byte >> 1;
      flags_left--;
      if (remaining == 0) phase = PH_DONE;
      else if (flags_left == 0) phase = PH_FLAG;
      else phase = PH_ITEM;
    endfunction

    // works out the decompressed bytes caused by one accepted input byte
    function void note_input(logic [7:0] b, logic sos);
      int                  before_cnt;
      logic [15:0]         word;
      logic [WIN_BITS-1:0] back_dist;
      int                  len;
      plain_beat_t         tail;
      before_cnt = pending_bytes.size();
      if (sos) begin
        phase      = PH_HEADER;
        hdr_idx    = '0;
        flag_byte  = '0;
        flags_left = '0;
        word_lo    = '0;
        remaining  = '0;
      end
      case (phase)
        PH_HEADER: begin
          if (hdr_idx >= 4) remaining |= 32'(b) << (8 * (hdr_idx - 4));
          if (hdr_idx >= 7) begin
            hdr_idx = '0;
            phase   = (remaining == 0) ? PH_DONE : PH_FLAG;
          end else begin
            hdr_idx++;
          end
        end
        PH_FLAG: begin
          flag_byte  = b;
          flags_left = 4'd8;
          phase      = PH_ITEM;
        end
        PH_ITEM: begin
          if (flag_byte[0]) begin
            emit(b);
            next_flag();
          end else begin
            word_lo = b;
            phase   = PH_WORD_HIGH;
          end
        end
        PH_WORD_HIGH: begin
          word      = {b, word_lo};
          back_dist = word[15:LEN_BITS];
          len       = int'(word[LEN_BITS-1:0]) + MIN_MATCH;
          for (int i = 0; i < len && (pending_bytes.size() - before_cnt) < MAX_RESULTS
               && remaining != 0; i++)
            emit(window[wr_pos - back_dist]);
          next_flag();
        end
        default: phase = PH_DONE;
      endcase
      if (pending_bytes.size() > before_cnt) begin
        tail      = pending_bytes.pop_back();
        tail.last = 1'b1;
        pending_bytes.push_back(tail);
      end
    endfunction

    function void fault(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void check_output(logic [7:0] d, logic last, logic eod);
      plain_beat_t want;
      seen++;
      if (pending_bytes.size() == 0) begin
        fault($sformatf("output %0d unexpected: byte %h last %b end %b", seen, d, last, eod));
        return;
      end
      want = pending_bytes.pop_front();
      if (want != {d, last, eod})
        fault($sformatf("output %0d: expected byte %h last %b end %b, got byte %h last %b end %b",
                        seen, want.data, want.last, want.eod, d, last, eod));
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction

    function void close();
      if (pending_bytes.size() != 0)
        fault($sformatf("%0d expected output bytes never arrived", pending_bytes.size()));
    endfunction
  endclass

endpackage

@@ tb/sv/tb_lzss_stream_decompressor_core.sv @@
// testbench for the lzss stream decompressor core: random compressed streams, predicted output
module tb_lzss_stream_decompressor_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lzsd_pkg::*;
  import lzsd_tb_pkg::*;

  localparam int IDLE_PCT     = 16;      // chance of a gap or stall per cycle
  localparam int ITEM_TARGET  = 180;     // random stream bytes to send
  localparam int DRAIN_CYCLES = 40;      // quiet time after the last expected byte
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [7:0] data;
    logic       sos;
  } comp_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = '0;
  logic       start_of_stream = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       end_of_data;

  decomp_scoreboard board;
  comp_beat_t       stream_bytes [$];
  bit               calm = 1'b0;   // no gaps and no stalls while set
  int               sent = 0;
  int               cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lzss_stream_decompressor_core i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .start_of_stream (start_of_stream),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .last_of_run     (last_of_run),
    .end_of_data     (end_of_data)
  );

  // receiver: check each output transfer, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) board.check_output(out_byte, last_of_run, end_of_data);
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("lzss_stream_decompressor_core: mismatch");
      $finish;
    end
  end

  // one input transfer; valid is only dropped when a gap is taken
  task automatic send_byte(input logic [7:0] b, input logic sos);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < IDLE_PCT);
    end
    in_valid        <= 1'b1;
    in_byte         <= b;
    start_of_stream <= sos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(b, sos);
  endtask

  task automatic play_stream();
    comp_beat_t beat;
    while (stream_bytes.size() != 0) begin
      beat = stream_bytes.pop_front();
      send_byte(beat.data, beat.sos);
    end
  endtask

  function automatic void push_byte(input logic [7:0] b, input logic sos);
    stream_bytes.push_back('{data: b, sos: sos});
  endfunction

  // well-formed stream with random content; cut keeps only that many bytes (0 keeps all)
  function automatic void build_stream(input logic [31:0] size, input int cut);
    logic [7:0]  flags;
    logic [11:0] back_dist;
    logic [3:0]  len_code;
    longint      made;
    for (int i = 0; i < 4; i++) push_byte(8'($urandom), i == 0);
    for (int i = 0; i < 4; i++) push_byte(size[8*i +: 8], 1'b0);
    made = 0;
    while (made < size && (cut == 0 || stream_bytes.size() < cut)) begin
      flags = 8'($urandom);
      push_byte(flags, 1'b0);
      for (int k = 0; k < 8 && made < size; k++) begin
        if (flags[k]) begin
          push_byte(8'($urandom), 1'b0);
          made++;
        end else begin
          len_code = 4'($urandom);
          // mostly short distances into this stream, some anywhere, some zero
          case ($urandom_range(0, 7))
            0:       back_dist = '0;
            1, 2:    back_dist = 12'($urandom);
            default: back_dist = 12'($urandom_range(1, int'(made) + 2));
          endcase
          push_byte({back_dist[3:0], len_code}, 1'b0);
          push_byte(back_dist[11:4], 1'b0);
          made += len_code + MIN_MATCH;
        end
      end
    end
    while (cut != 0 && stream_bytes.size() > cut) void'(stream_bytes.pop_back());
  endfunction

  initial begin
    logic [31:0] size;
    int          cut;
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // zero original size, sent with no start marker right after reset
    for (int i = 0; i < 4; i++) push_byte(8'hff, 1'b0);
    for (int i = 0; i < 4; i++) push_byte(8'h00, 1'b0);
    // size four: a literal, then a zero-distance match of 17 clipped to three
    push_byte(8'h00, 1'b1);
    for (int i = 0; i < 3; i++) push_byte(8'hff, 1'b0);
    push_byte(8'h04, 1'b0);
    for (int i = 0; i < 3; i++) push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h0f, 1'b0);
    push_byte(8'h00, 1'b0);
    // byte after the end is ignored
    push_byte(8'h5a, 1'b0);
    play_stream();

    while (sent < ITEM_TARGET) begin
      calm = (sent >= 70 && sent < 115);
      cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 20) : 0;
      case ($urandom_range(0, 15))
        0:       size = '0;
        1: begin
          // huge size never completes, so the stream is broken off
          size = {8'($urandom_range(1, 255)), 24'($urandom)};
          cut  = $urandom_range(10, 24);
        end
        default: size = $urandom_range(1, 48);
      endcase
      build_stream(size, cut);
      sent += stream_bytes.size();
      if (cut == 0 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
      play_stream();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.close();
    if (board.errors == 0)
      $display("lzss_stream_decompressor_core: match");
    else
      $display("lzss_stream_decompressor_core: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/lzsd_pkg.sv
rtl/lzsd_ram.sv
rtl/lzss_stream_decompressor_core.sv
tb/sv/lzsd_tb_pkg.sv
tb/sv/tb_lzss_stream_decompressor_core.sv
